// ===== src/lhc_pkg.sv =====
// shared types and constants for the lru handle cache
package lhc_pkg;

    // fixed field widths
    localparam int ID_W      = 32;
    localparam int SLOT_W    = 4;
    localparam int TOTAL_W   = 32;
    localparam int TDATA_W   = 104;

    // result bit offsets inside the output tdata
    localparam int OFS_SLOT   = 0;
    localparam int OFS_HIT    = 4;
    localparam int OFS_OPEN   = 5;
    localparam int OFS_EVICT  = 6;
    localparam int OFS_EVID   = 7;
    localparam int OFS_ERR    = 39;
    localparam int OFS_HITS   = 40;
    localparam int OFS_MISSES = 72;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FL_RD,
        ST_FL_OUT
    } t_state;

    // kind of result loaded into the output register
    typedef enum logic [1:0] {
        RES_ASSOC,
        RES_DIRECT,
        RES_FLUSH
    } t_res_kind;

    // controller to datapath
    typedef struct packed {
        logic      start;
        logic      scan_step;
        logic      flush_step;
        logic      out_load;
        t_res_kind res_kind;
        logic      clear_store;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_flush;
        logic direct;
        logic idx_last;
        logic idx_occ;
        logic occ_above;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/lhc_ctrl.sv =====
// controller state machine for the lru handle cache
module lhc_ctrl
    import lhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.res_kind    = RES_ASSOC;
        o_in_ready        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.in_flush) begin
                        n_state = ST_FL_RD;
                    end else if (i_status.direct) begin
                        n_state = ST_DIRECT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DIRECT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res_kind = RES_DIRECT;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res_kind = RES_ASSOC;
                    n_state        = ST_IDLE;
                end
            end
            ST_FL_RD: begin
                if (i_status.idx_occ) begin
                    n_state = ST_FL_OUT;
                end else if (i_status.idx_last) begin
                    o_cmd.clear_store = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    o_cmd.flush_step = 1'b1;
                end
            end
            ST_FL_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res_kind = RES_FLUSH;
                    if (!i_status.occ_above) begin
                        o_cmd.clear_store = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.flush_step = 1'b1;
                        n_state          = ST_FL_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lhc_dp.sv =====
// datapath of the lru handle cache: tag and age memories, occupancy, totals, output register
module lhc_dp
    import lhc_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int AGE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [ID_W-1:0]    i_cfg_wdata,
    input  logic               i_in_mode,
    input  logic [ID_W-1:0]    i_in_id,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [TDATA_W-1:0] o_out_data,
    output logic               o_out_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0]       IDX_LAST = SW'(SLOTS - 1);
    localparam logic [AGE_BITS-1:0] AGE_ONE  = AGE_BITS'(1);

    // configuration and request
    logic [ID_W-1:0]     r_id_count;
    logic [ID_W-1:0]     r_req_id;

    // per-slot flags and memories
    logic [SLOTS-1:0]    r_occ;
    logic [SLOTS-1:0]    r_age_vld;
    logic [ID_W-1:0]     r_tag_mem [SLOTS];
    logic [AGE_BITS-1:0] r_age_mem [SLOTS];

    // slot walk and read pipeline
    logic [SW-1:0]       r_idx;
    logic [SW-1:0]       r_rd_idx;
    logic [ID_W-1:0]     r_tag_q;
    logic [AGE_BITS-1:0] r_age_q;
    logic                r_occ_q;
    logic                r_agev_q;
    logic                r_scan_vld;

    // scan results
    logic                r_found_vld;
    logic [SW-1:0]       r_found_idx;
    logic [AGE_BITS-1:0] r_best;
    logic [SW-1:0]       r_vict_idx;
    logic [ID_W-1:0]     r_vict_tag;
    logic                r_vict_occ;

    // totals and output register
    logic [TOTAL_W-1:0]  r_hits;
    logic [TOTAL_W-1:0]  r_misses;
    logic                r_out_vld;
    logic [TDATA_W-1:0]  r_out_data;
    logic                r_out_last;

    logic [AGE_BITS-1:0] age_cur;
    logic [AGE_BITS-1:0] age_inc;
    logic [SW-1:0]       victim;
    logic [SW-1:0]       dir_idx;
    logic                dir_err;
    logic                dir_occ;
    logic                occ_above;
    logic                assoc_load;
    logic                direct_load;
    logic [TOTAL_W-1:0]  n_hits;
    logic [TOTAL_W-1:0]  n_misses;

    logic                tag_we;
    logic [SW-1:0]       tag_wa;
    logic                age_we;
    logic [SW-1:0]       age_wa;
    logic [AGE_BITS-1:0] age_wd;

    logic [SW-1:0]       res_idx;
    logic [SW+3:0]       res_idx_ext;
    logic                res_hit;
    logic                res_open;
    logic                res_ev;
    logic [ID_W-1:0]     res_evid;
    logic                res_err;
    logic                res_last;

    // age of the slot just read, saturating increment
    assign age_cur = r_agev_q ? r_age_q : '0;
    assign age_inc = (age_cur == '1) ? age_cur : age_cur + AGE_ONE;

    assign victim  = r_found_vld ? r_found_idx : r_vict_idx;
    assign dir_idx = r_req_id[SW-1:0];
    assign dir_err = (r_req_id >= r_id_count);
    assign dir_occ = r_occ[dir_idx];

    assign assoc_load  = i_cmd.out_load && (i_cmd.res_kind == RES_ASSOC);
    assign direct_load = i_cmd.out_load && (i_cmd.res_kind == RES_DIRECT);

    assign n_hits   = r_hits + TOTAL_W'(assoc_load && r_found_vld);
    assign n_misses = r_misses + TOTAL_W'(assoc_load && !r_found_vld);

    // any occupied slot above the current one
    always_comb begin
        occ_above = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (r_occ[j] && (j > int'(r_idx))) begin
                occ_above = 1'b1;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_status.in_flush  = i_in_mode;
        o_status.direct    = ({1'b0, r_id_count} <= (ID_W + 1)'(SLOTS));
        o_status.idx_last  = (r_idx == IDX_LAST);
        o_status.idx_occ   = r_occ[r_idx];
        o_status.occ_above = occ_above;
        o_status.out_free  = !r_out_vld || i_out_ready;
    end

    // memory write selection
    always_comb begin
        tag_we = 1'b0;
        tag_wa = victim;
        if (assoc_load && !r_found_vld) begin
            tag_we = 1'b1;
            tag_wa = victim;
        end else if (direct_load && !dir_err && !dir_occ) begin
            tag_we = 1'b1;
            tag_wa = dir_idx;
        end
        age_we = 1'b0;
        age_wa = r_rd_idx;
        age_wd = age_inc;
        if (r_scan_vld) begin
            age_we = 1'b1;
        end else if (assoc_load) begin
            age_we = 1'b1;
            age_wa = victim;
            age_wd = AGE_ONE;
        end
    end

    // tag memory
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_wa] <= r_req_id;
        end
        r_tag_q <= r_tag_mem[r_idx];
    end

    // age memory
    always_ff @(posedge i_clk) begin
        if (age_we) begin
            r_age_mem[age_wa] <= age_wd;
        end
        r_age_q <= r_age_mem[r_idx];
    end

    // flags that travel with the read data
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        r_occ_q  <= r_occ[r_idx];
        r_agev_q <= r_age_vld[r_idx];
    end

    // occupancy and age valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_age_vld <= '0;
        end else if (i_cfg_we || i_cmd.clear_store) begin
            r_occ     <= '0;
            r_age_vld <= '0;
        end else begin
            if (tag_we) begin
                r_occ[tag_wa] <= 1'b1;
            end
            if (age_we) begin
                r_age_vld[age_wa] <= 1'b1;
            end
        end
    end

    // id count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_count <= '1;
        end else if (i_cfg_we) begin
            r_id_count <= i_cfg_wdata;
        end
    end

    // slot walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_step;
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if ((i_cmd.scan_step || i_cmd.flush_step) && (r_idx != IDX_LAST)) begin
                r_idx <= r_idx + SW'(1);
            end
        end
    end

    // request capture and scan tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_id    <= i_in_id;
            r_found_vld <= 1'b0;
            r_found_idx <= '0;
            r_best      <= '0;
            r_vict_idx  <= '0;
            r_vict_tag  <= '0;
            r_vict_occ  <= 1'b0;
        end else if (r_scan_vld) begin
            if (r_occ_q && (r_tag_q == r_req_id)) begin
                r_found_vld <= 1'b1;
                r_found_idx <= r_rd_idx;
            end
            if (age_cur >= r_best) begin
                r_best     <= age_cur;
                r_vict_idx <= r_rd_idx;
                r_vict_tag <= r_tag_q;
                r_vict_occ <= r_occ_q;
            end
        end
    end

    // hit and miss totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (assoc_load) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    // result fields by kind
    always_comb begin
        res_idx  = '0;
        res_hit  = 1'b0;
        res_open = 1'b0;
        res_ev   = 1'b0;
        res_evid = '0;
        res_err  = 1'b0;
        res_last = 1'b1;
        case (i_cmd.res_kind)
            RES_ASSOC: begin
                res_idx  = victim;
                res_hit  = r_found_vld;
                res_open = !r_found_vld;
                res_ev   = !r_found_vld && r_vict_occ;
                res_evid = res_ev ? r_vict_tag : '0;
            end
            RES_DIRECT: begin
                if (dir_err) begin
                    res_err = 1'b1;
                end else begin
                    res_idx  = dir_idx;
                    res_hit  = dir_occ;
                    res_open = !dir_occ;
                end
            end
            RES_FLUSH: begin
                res_idx  = r_idx;
                res_ev   = 1'b1;
                res_evid = r_tag_q;
                res_last = !occ_above;
            end
            default: begin
                res_idx = '0;
            end
        endcase
    end

    assign res_idx_ext = {4'b0000, res_idx};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {n_misses, n_hits, res_err, res_evid, res_ev, res_open,
                           res_hit, res_idx_ext[SLOT_W-1:0]};
            r_out_last <= res_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// ===== src/lru_handle_cache.sv =====
// top level of the lru handle cache
//
// usage: requests enter on the s_axis channel (tuser = mode, 0 lookup, 1 flush;
// tdata = id). results leave on the m_axis channel, tlast on the final result of
// each request. id_count is written through i_cfg_we / i_cfg_wdata while idle;
// a write empties the store, totals are kept.
// one request is handled at a time.
//   associative lookup: accept, one slot read per cycle over the tag and age
//   memories, drain of the read pipeline, commit
//   direct lookup: accept, then load of the result once the output register is free
//   flush: a read of each slot up to the last occupied one, an output step per closed slot
// the slot-serial walk, one read a cycle from the tag and age memories, sets the
// lookup time. results sit in an output register, so the next request is taken
// while the last result still waits on m_axis_tready; a stalled receiver holds
// a multi-result flush at the next result.
// reset: synchronous, active low; empties the store, clears the totals and
// returns id_count to all ones (associative mode).
module lru_handle_cache
    import lhc_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int AGE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [ID_W-1:0]    s_axis_tdata,   // id
    input  logic [0:0]         s_axis_tuser,   // mode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // slot, hit, open_needed, evict_valid, evicted_id, id_error, hits_total, misses_total
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,
    input  logic               i_cfg_we,
    input  logic [ID_W-1:0]    i_cfg_wdata
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // controller
    lhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    lhc_dp #(
        .SLOTS    (SLOTS),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_mode   (s_axis_tuser[0]),
        .i_in_id     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== src/lhc_checker.sv =====
// port-level checks for the lru handle cache, bound to the top level
module lhc_checker
    import lhc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // one request at a time: no new transaction right after one is taken
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // an id error result is a lone final result with no other flags
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OFS_ERR] |->
            m_axis_tlast && !m_axis_tdata[OFS_HIT] && !m_axis_tdata[OFS_OPEN]
            && !m_axis_tdata[OFS_EVICT])
        else $error("id error result carries other flags");

endmodule

bind lru_handle_cache lhc_checker u_lhc_checker (.*);

// ===== tb/tb.sv =====
// testbench for the lru handle cache: stream driver, predictor and scoreboard
`timescale 1ns / 1ps

module tb;
    import lhc_pkg::*;

    localparam int          CLK_PERIOD    = 20;
    localparam int          NUM_SLOTS     = 16;
    localparam logic [15:0] AGE_MAX       = 16'hffff;
    localparam logic [31:0] ID_NONE       = 32'hffffffff;
    localparam int          SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          MAX_PRINT     = 40;
    localparam longint     TIMEOUT_NS     = 64'd10_000_000;

    // request kind carried on s_axis_tuser
    typedef enum bit {
        REQ_LOOKUP = 1'b0,
        REQ_FLUSH  = 1'b1
    } t_req_mode;

    // one result as the block reports it
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               open_needed;
        logic               evict_valid;
        logic [ID_W-1:0]    evicted_id;
        logic               id_error;
        logic               last;
        logic [TOTAL_W-1:0] hits_total;
        logic [TOTAL_W-1:0] misses_total;
    } t_handle_res;

    // handle store model and queue of awaited results
    class handle_scoreboard;
        logic [ID_W-1:0]    id_count;
        logic [ID_W-1:0]    tag [NUM_SLOTS];
        bit                 occ [NUM_SLOTS];
        logic [15:0]        age [NUM_SLOTS];
        logic [TOTAL_W-1:0] hit_cnt;
        logic [TOTAL_W-1:0] miss_cnt;
        t_handle_res        awaited [$];
        int errors, requests, results;
        int n_hits, n_misses, n_evicts, n_closes, n_opens, n_id_err, n_settings;

        function new();
            id_count = ID_NONE;
            hit_cnt  = '0;
            miss_cnt = '0;
            empty_store();
        endfunction

        function void empty_store();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tag[i] = ID_NONE;
                occ[i] = 1'b0;
                age[i] = '0;
            end
        endfunction

        function void set_id_count(logic [ID_W-1:0] v);
            id_count = v;
            n_settings++;
            empty_store();
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // work out the results of one accepted transaction
        function void note_request(t_req_mode mode, logic [ID_W-1:0] id);
            t_handle_res r;
            int          last_occ;
            int          found;
            int          victim;
            logic [15:0] oldest;
            requests++;
            r              = '0;
            r.hits_total   = hit_cnt;
            r.misses_total = miss_cnt;
            r.last         = 1'b1;
            // flush: close every occupied slot in slot order
            if (mode == REQ_FLUSH) begin
                last_occ = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (occ[i]) last_occ = i;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (occ[i]) begin
                        r.slot        = i[SLOT_W-1:0];
                        r.evict_valid = 1'b1;
                        r.evicted_id  = tag[i];
                        r.last        = (i == last_occ);
                        awaited.push_back(r);
                        n_closes++;
                    end
                end
                empty_store();
                return;
            end
            // direct table
            if (id_count <= NUM_SLOTS) begin
                if (id >= id_count) begin
                    r.id_error = 1'b1;
                    n_id_err++;
                end else if (occ[id[SLOT_W-1:0]]) begin
                    r.slot = id[SLOT_W-1:0];
                    r.hit  = 1'b1;
                end else begin
                    occ[id[SLOT_W-1:0]] = 1'b1;
                    tag[id[SLOT_W-1:0]] = id;
                    r.slot        = id[SLOT_W-1:0];
                    r.open_needed = 1'b1;
                    n_opens++;
                end
                awaited.push_back(r);
                return;
            end
            // associative lookup with age based victim choice
            found = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (occ[i] && tag[i] == id) found = i;
            if (found >= 0) begin
                victim  = found;
                hit_cnt = hit_cnt + 1;
                r.hit   = 1'b1;
                n_hits++;
            end else begin
                miss_cnt = miss_cnt + 1;
                oldest   = '0;
                victim   = 0;
                // ties go to the highest index
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (age[i] >= oldest) begin
                        oldest = age[i];
                        victim = i;
                    end
                end
                if (occ[victim]) begin
                    r.evict_valid = 1'b1;
                    r.evicted_id  = tag[victim];
                    n_evicts++;
                end
                tag[victim]   = id;
                occ[victim]   = 1'b1;
                r.open_needed = 1'b1;
                n_misses++;
            end
            age[victim] = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (age[i] != AGE_MAX) age[i] = age[i] + 1;
            r.slot         = victim[SLOT_W-1:0];
            r.hits_total   = hit_cnt;
            r.misses_total = miss_cnt;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                          results, name, got, want));
        endtask

        // compare one accepted result with the oldest awaited one
        task check_result(logic [TDATA_W-1:0] data, logic tl);
            t_handle_res got;
            t_handle_res want;
            got.slot         = data[OFS_SLOT +: SLOT_W];
            got.hit          = data[OFS_HIT];
            got.open_needed  = data[OFS_OPEN];
            got.evict_valid  = data[OFS_EVICT];
            got.evicted_id   = data[OFS_EVID +: ID_W];
            got.id_error     = data[OFS_ERR];
            got.last         = tl;
            got.hits_total   = data[OFS_HITS +: TOTAL_W];
            got.misses_total = data[OFS_MISSES +: TOTAL_W];
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h", data));
                return;
            end
            want = awaited.pop_front();
            results++;
            check_field("slot", got.slot, want.slot);
            check_field("hit", got.hit, want.hit);
            check_field("open_needed", got.open_needed, want.open_needed);
            check_field("evict_valid", got.evict_valid, want.evict_valid);
            check_field("evicted_id", got.evicted_id, want.evicted_id);
            check_field("id_error", got.id_error, want.id_error);
            check_field("tlast", got.last, want.last);
            check_field("hits_total", got.hits_total, want.hits_total);
            check_field("misses_total", got.misses_total, want.misses_total);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [ID_W-1:0]    s_axis_tdata = '0;      // id
    logic [0:0]         s_axis_tuser = '0;      // mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // slot, hit, open_needed, evict_valid, evicted_id, id_error, hits_total, misses_total
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [ID_W-1:0]    i_cfg_wdata = '0;

    handle_scoreboard sb = new();
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    logic             sink_hold = 1'b0;
    event             hold_kick;
    logic [ID_W-1:0]  pool_base;

    lru_handle_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver readiness with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_kick);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            sink_hold <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // offer one transaction, with random idle cycles ahead of it
    task automatic send_item(input t_req_mode mode, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(mode, id);
    endtask

    // stop offering and wait for every awaited result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_id_count(input logic [ID_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_id_count(v);
    endtask

    // random mix: mostly lookups from a small id pool, some noise and flushes
    task automatic random_items(input int n, input int pool);
        logic [ID_W-1:0] id;
        int              roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                send_item(REQ_FLUSH, $urandom());
            end else begin
                if (sb.id_count <= NUM_SLOTS) begin
                    if (sb.id_count == 0 || roll < 14)
                        id = $urandom();
                    else if (roll < 24)
                        id = sb.id_count + $urandom_range(0, 3);
                    else
                        id = $urandom_range(0, sb.id_count - 1);
                end else begin
                    if (roll < 15)
                        id = $urandom();
                    else
                        id = pool_base + $urandom_range(0, pool - 1);
                end
                send_item(REQ_LOOKUP, id);
            end
        end
    endtask

    // stimulus
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // associative mode from reset: empty flush, extremes, fill, evict, full flush
        pool_base = $urandom();
        send_item(REQ_FLUSH, ID_NONE);
        send_item(REQ_LOOKUP, 32'h0);
        send_item(REQ_LOOKUP, ID_NONE);
        send_item(REQ_LOOKUP, 32'h0);
        send_item(REQ_LOOKUP, ID_NONE);
        for (int i = 1; i <= 14; i++)
            send_item(REQ_LOOKUP, i);
        send_item(REQ_LOOKUP, 32'h1234_5678);
        send_item(REQ_LOOKUP, 32'ha5a5_a5a5);
        send_item(REQ_FLUSH, 32'h0);
        random_items(70, 22);

        // direct table at its largest
        src_idle_pct = 51;
        write_id_count(NUM_SLOTS);
        send_item(REQ_LOOKUP, 32'd0);
        send_item(REQ_LOOKUP, 32'd15);
        send_item(REQ_LOOKUP, 32'd15);
        send_item(REQ_LOOKUP, 32'd16);
        send_item(REQ_LOOKUP, ID_NONE);
        send_item(REQ_FLUSH, ID_NONE);
        random_items(60, 1);

        // zero ids: every lookup is out of range
        src_idle_pct  = 0;
        snk_stall_pct = 51;
        write_id_count(32'd0);
        send_item(REQ_LOOKUP, 32'd0);
        send_item(REQ_LOOKUP, ID_NONE);
        send_item(REQ_FLUSH, 32'd0);
        random_items(15, 1);

        // smallest associative setting
        src_idle_pct  = 37;
        snk_stall_pct = 37;
        pool_base     = $urandom();
        write_id_count(NUM_SLOTS + 1);
        random_items(80, 20);

        // single entry direct table
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_id_count(32'd1);
        random_items(25, 1);

        src_idle_pct = 51;
        write_id_count(32'd5);
        random_items(40, 1);

        // largest id_count, with a long receiver hold-off
        src_idle_pct  = 37;
        snk_stall_pct = 37;
        pool_base     = $urandom();
        write_id_count(ID_NONE);
        random_items(30, 24);
        src_idle_pct = 0;
        ->hold_kick;
        random_items(14, 24);
        drain();
        src_idle_pct = 37;
        random_items(45, 24);

        src_idle_pct  = 0;
        snk_stall_pct = 51;
        pool_base     = $urandom();
        write_id_count(32'd2048);
        random_items(40, 18);

        drain();
        $display("covered %0d requests over %0d id_count settings, %0d results checked",
                 sb.requests, sb.n_settings, sb.results);
        $display("hits %0d, misses %0d, evictions %0d, flush closes %0d, opens %0d, id errors %0d",
                 sb.n_hits, sb.n_misses, sb.n_evicts, sb.n_closes, sb.n_opens, sb.n_id_err);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.outstanding());
        $display("TEST FAILED");
        $finish;
    end

endmodule
